### design/ppg_pkg.sv
// ----------------------------------------------------------------------------
// ppg_pkg
// Shared types, register indexes, reset values and the cosine table of the
// plasma pixel generator.
// ----------------------------------------------------------------------------
package ppg_pkg;

   localparam int MaxDim  = 256;
   localparam int MaxLog2 = $clog2(MaxDim + 1) - 1;

   typedef enum logic [2:0] {
      CSR_WIDTH_LOG2   = 3'd0,
      CSR_HEIGHT_LOG2  = 3'd1,
      CSR_LINE_STEPS   = 3'd2,
      CSR_FRAME_STEPS  = 3'd3,
      CSR_OFFSET_STEPS = 3'd4
   } csr_index_type;

   localparam logic [3:0]  RstWidthLog2   = 4'd6;
   localparam logic [3:0]  RstHeightLog2  = 4'd6;
   localparam logic [31:0] RstLineSteps   = 32'h0201_0403;
   localparam logic [31:0] RstFrameSteps  = 32'h01FE_03FC;
   localparam logic [15:0] RstOffsetSteps = 16'hFD02;
   localparam logic [7:0]  RstWarpOffset0 = 8'd0;
   localparam logic [7:0]  RstWarpOffset1 = 8'd1;

   typedef struct packed {
      logic [7:0]  wmask;
      logic [7:0]  hmask;
      logic [2:0]  sw;
      logic [2:0]  sh;
      logic [31:0] line_steps;
      logic [31:0] frame_steps;
      logic [15:0] offset_steps;
   } cfg_type;

   typedef struct packed {
      logic [3:0][7:0] phase;
      logic [1:0][7:0] offset;
   } anim_type;

   localparam logic [5:0] CosQuarter [0:64] = '{
      6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63,
      6'd63, 6'd62, 6'd62, 6'd62, 6'd62, 6'd61, 6'd61, 6'd61, 6'd60, 6'd60,
      6'd60, 6'd59, 6'd59, 6'd59, 6'd58, 6'd58, 6'd57, 6'd57, 6'd56, 6'd56,
      6'd55, 6'd55, 6'd54, 6'd54, 6'd53, 6'd52, 6'd52, 6'd51, 6'd51, 6'd50,
      6'd49, 6'd49, 6'd48, 6'd47, 6'd47, 6'd46, 6'd45, 6'd44, 6'd44, 6'd43,
      6'd42, 6'd42, 6'd41, 6'd40, 6'd39, 6'd39, 6'd38, 6'd37, 6'd36, 6'd35,
      6'd35, 6'd34, 6'd33, 6'd32, 6'd32
   };

   // full-circle cosine from the quarter table, values 0..63
   function automatic logic [5:0] cos_rom(input logic [7:0] idx);
      logic [7:0] i;
      logic [5:0] r;
      i = idx;
      if (idx > 8'd128) begin
         i = 8'(9'd256 - {1'b0, idx});
      end
      if (i <= 8'd64) begin
         r = CosQuarter[i[6:0]];
      end else begin
         r = 6'd63 - CosQuarter[7'(8'd128 - i)];
      end
      return r;
   endfunction

endpackage

### design/ppg_csr.sv
// ----------------------------------------------------------------------------
// ppg_csr
// Configuration registers with frame size clamping, shift and mask decode.
// ----------------------------------------------------------------------------
module ppg_csr (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [2:0]             csr_index,
   input  logic [31:0]            csr_wr_data,
   output ppg_pkg::cfg_type       cfg
);
   import ppg_pkg::*;

   logic [3:0]  width_log2_ff;
   logic [3:0]  height_log2_ff;
   logic [31:0] line_steps_ff;
   logic [31:0] frame_steps_ff;
   logic [15:0] offset_steps_ff;
   logic [3:0]  wl;
   logic [3:0]  hl;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff   <= RstWidthLog2;
         height_log2_ff  <= RstHeightLog2;
         line_steps_ff   <= RstLineSteps;
         frame_steps_ff  <= RstFrameSteps;
         offset_steps_ff <= RstOffsetSteps;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_WIDTH_LOG2:   width_log2_ff   <= csr_wr_data[3:0];
            CSR_HEIGHT_LOG2:  height_log2_ff  <= csr_wr_data[3:0];
            CSR_LINE_STEPS:   line_steps_ff   <= csr_wr_data;
            CSR_FRAME_STEPS:  frame_steps_ff  <= csr_wr_data;
            CSR_OFFSET_STEPS: offset_steps_ff <= csr_wr_data[15:0];
            default: ;
         endcase
      end
   end

   function automatic logic [3:0] clamp_log2(input logic [3:0] v);
      logic [3:0] r;
      r = v;
      if (v < 4'd1) begin
         r = 4'd1;
      end else if (v > 4'(MaxLog2)) begin
         r = 4'(MaxLog2);
      end
      return r;
   endfunction

   always_comb begin
      wl               = clamp_log2(width_log2_ff);
      hl               = clamp_log2(height_log2_ff);
      cfg.sw           = 3'(4'd8 - wl);
      cfg.sh           = 3'(4'd8 - hl);
      cfg.wmask        = 8'((9'd1 << wl) - 9'd1);
      cfg.hmask        = 8'((9'd1 << hl) - 9'd1);
      cfg.line_steps   = line_steps_ff;
      cfg.frame_steps  = frame_steps_ff;
      cfg.offset_steps = offset_steps_ff;
   end

endmodule

### design/ppg_anim.sv
// ----------------------------------------------------------------------------
// ppg_anim
// Animation state: four frame phases and two warp offsets, advanced on an
// accepted beat that marks the end of a frame.
// ----------------------------------------------------------------------------
module ppg_anim (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  ppg_pkg::cfg_type       cfg,
   output ppg_pkg::anim_type      anim
);
   import ppg_pkg::*;

   anim_type anim_ff;
   anim_type anim_in;

   always_comb begin
      anim_in = anim_ff;
      if (advance) begin
         for (int k = 0; k < 4; k++) begin
            anim_in.phase[k] = anim_ff.phase[k] + cfg.frame_steps[8*k +: 8];
         end
         for (int k = 0; k < 2; k++) begin
            anim_in.offset[k] = anim_ff.offset[k] + cfg.offset_steps[8*k +: 8];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anim_ff.phase     <= '0;
         anim_ff.offset[0] <= RstWarpOffset0;
         anim_ff.offset[1] <= RstWarpOffset1;
      end else begin
         anim_ff <= anim_in;
      end
   end

   assign anim = anim_ff;

   a_hold_without_frame_end: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(anim_ff))
      else $error("animation state moved without a frame end beat");

endmodule

### design/ppg_datapath.sv
// ----------------------------------------------------------------------------
// ppg_datapath
// Four-stage pixel pipeline: capture, phase forming, cosine lookups with the
// column warp, then shade sum with the row warp into the output register.
// ----------------------------------------------------------------------------
module ppg_datapath (
   input  logic                   clock,
   input  logic                   reset,
   input  ppg_pkg::cfg_type       cfg,
   input  ppg_pkg::anim_type      anim,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [7:0]             req_x,
   input  logic [7:0]             req_y,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [7:0]             rsp_x_dst,
   output logic [7:0]             rsp_y_dst,
   output logic [7:0]             rsp_shade
);
   import ppg_pkg::*;

   logic adv0, adv1, adv2, adv3;

   // capture stage
   logic            v0_ff;
   logic [7:0]      xm0_ff, ym0_ff;
   anim_type        anim0_ff;

   // phase stage
   logic            v1_ff;
   logic [7:0]      xm1_ff, ym1_ff;
   logic [3:0][7:0] p1_ff;
   logic [3:0][7:0] p1_in;
   logic [7:0]      idx1_ff, idx1_in;
   logic [7:0]      wo1_ff;

   // lookup stage
   logic            v2_ff;
   logic [7:0]      ym2_ff;
   logic [3:0][5:0] c2_ff;
   logic [3:0][5:0] c2_in;
   logic [7:0]      thex2_ff, thex2_in;
   logic [7:0]      wo2_ff;

   // output stage
   logic            v3_ff;
   logic [7:0]      x3_ff, y3_ff, shade3_ff;
   logic [7:0]      x3_in, y3_in, shade3_in;
   logic [7:0]      idx3;
   logic [7:0]      coord;
   logic [15:0]     prod;

   assign adv3      = !v3_ff || rsp_ready;
   assign adv2      = !v2_ff || adv3;
   assign adv1      = !v1_ff || adv2;
   assign adv0      = !v0_ff || adv1;
   assign req_ready = adv0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (adv0) v0_ff <= req_valid;
         if (adv1) v1_ff <= v0_ff;
         if (adv2) v2_ff <= v1_ff;
         if (adv3) v3_ff <= v2_ff;
      end
   end

   always_comb begin
      p1_in = '0;
      for (int k = 0; k < 4; k++) begin
         coord    = (k < 2) ? xm0_ff : ym0_ff;
         prod     = coord * cfg.line_steps[8*k +: 8];
         p1_in[k] = anim0_ff.phase[k] + 8'(prod[7:0] << cfg.sw);
      end
      idx1_in = 8'(ym0_ff << cfg.sh) + anim0_ff.offset[0];
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         c2_in[k] = cos_rom(p1_ff[k]);
      end
      thex2_in = xm1_ff + 8'(cos_rom(idx1_ff) >> cfg.sw);
   end

   always_comb begin
      shade3_in = 8'(c2_ff[0]) + 8'(c2_ff[1]) + 8'(c2_ff[2]) + 8'(c2_ff[3]);
      idx3      = 8'(thex2_ff << cfg.sw) + wo2_ff;
      x3_in     = thex2_ff & cfg.wmask;
      y3_in     = (ym2_ff + 8'(cos_rom(idx3) >> cfg.sh)) & cfg.hmask;
   end

   always_ff @(posedge clock) begin
      if (adv0) begin
         xm0_ff   <= req_x & cfg.wmask;
         ym0_ff   <= req_y & cfg.hmask;
         anim0_ff <= anim;
      end
      if (adv1) begin
         xm1_ff  <= xm0_ff;
         ym1_ff  <= ym0_ff;
         p1_ff   <= p1_in;
         idx1_ff <= idx1_in;
         wo1_ff  <= anim0_ff.offset[1];
      end
      if (adv2) begin
         ym2_ff   <= ym1_ff;
         c2_ff    <= c2_in;
         thex2_ff <= thex2_in;
         wo2_ff   <= wo1_ff;
      end
      if (adv3) begin
         x3_ff     <= x3_in;
         y3_ff     <= y3_in;
         shade3_ff <= shade3_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_x_dst = x3_ff;
   assign rsp_y_dst = y3_ff;
   assign rsp_shade = shade3_ff;

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !v3_ff |-> req_ready)
      else $error("input stalled with an empty output stage");

   a_shade_range: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (shade3_ff <= 8'd252))
      else $error("shade above the four-term maximum");

   a_dst_in_frame: assert property (@(posedge clock) disable iff (reset)
      v3_ff |-> (((x3_ff & ~cfg.wmask) == 8'd0) && ((y3_ff & ~cfg.hmask) == 8'd0)))
      else $error("destination outside the frame");

endmodule

### design/plasma_pixel_generator_unit.sv
// ----------------------------------------------------------------------------
// plasma_pixel_generator_unit
// Animated plasma texture: per pixel, a shade from four cosine phases and a
// warped destination coordinate.
//
//   channel  direction  handshake              payload
//   req      in         req_valid/req_ready    req_x, req_y, req_frame_end
//   rsp      out        rsp_valid/rsp_ready    rsp_x_dst, rsp_y_dst, rsp_shade
//   csr      in         csr_wr_en              csr_index, csr_wr_data
//
// one beat per cycle sustained while rsp_ready holds high
// the four pipeline stages each hold one beat, so the rate is one per clock
// reset empties the pipeline and loads register and animation defaults
// a stall on rsp freezes the stages back to front; no beat is lost or repeated
// frame phases advance on the accepted frame_end beat, after its own use
// ----------------------------------------------------------------------------
module plasma_pixel_generator_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_x,
   input  logic [7:0]  req_y,
   input  logic        req_frame_end,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_x_dst,
   output logic [7:0]  rsp_y_dst,
   output logic [7:0]  rsp_shade,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wr_data
);
   import ppg_pkg::*;

   cfg_type  cfg;
   anim_type anim;
   logic     advance;

   assign advance = req_valid && req_ready && req_frame_end;

   ppg_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   ppg_anim u_anim (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg),
      .anim    (anim)
   );

   ppg_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .anim      (anim),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_x     (req_x),
      .req_y     (req_y),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_x_dst (rsp_x_dst),
      .rsp_y_dst (rsp_y_dst),
      .rsp_shade (rsp_shade)
   );

endmodule

### bench/plasma_pixel_generator_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// plasma_pixel_generator_unit_tb
// Streams pixel beats through the plasma generator and checks each shade and
// warped destination against an in-bench model. The model tracks frame phases
// and warp offsets across frame ends. Register settings are changed between
// phases, with sender gaps and receiver stalls at varying rates.
// ----------------------------------------------------------------------------
module plasma_pixel_generator_unit_tb;
   import ppg_pkg::*;

   localparam int IdleLimit = 1000;

   localparam logic [5:0] QuarterCos [0:64] = '{
      6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63, 6'd63,
      6'd63, 6'd62, 6'd62, 6'd62, 6'd62, 6'd61, 6'd61, 6'd61, 6'd60, 6'd60,
      6'd60, 6'd59, 6'd59, 6'd59, 6'd58, 6'd58, 6'd57, 6'd57, 6'd56, 6'd56,
      6'd55, 6'd55, 6'd54, 6'd54, 6'd53, 6'd52, 6'd52, 6'd51, 6'd51, 6'd50,
      6'd49, 6'd49, 6'd48, 6'd47, 6'd47, 6'd46, 6'd45, 6'd44, 6'd44, 6'd43,
      6'd42, 6'd42, 6'd41, 6'd40, 6'd39, 6'd39, 6'd38, 6'd37, 6'd36, 6'd35,
      6'd35, 6'd34, 6'd33, 6'd32, 6'd32
   };

   typedef struct packed {
      logic [7:0] x_dst;
      logic [7:0] y_dst;
      logic [7:0] shade;
   } plasma_pixel_type;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        req_valid     = 1'b0;
   logic        req_ready;
   logic [7:0]  req_x         = '0;
   logic [7:0]  req_y         = '0;
   logic        req_frame_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready     = 1'b0;
   logic [7:0]  rsp_x_dst;
   logic [7:0]  rsp_y_dst;
   logic [7:0]  rsp_shade;
   logic        csr_wr_en     = 1'b0;
   logic [2:0]  csr_index     = '0;
   logic [31:0] csr_wr_data   = '0;

   // model copy of registers and animation state
   logic [3:0]  width_log2_q;
   logic [3:0]  height_log2_q;
   logic [31:0] line_steps_q;
   logic [31:0] frame_steps_q;
   logic [15:0] offset_steps_q;
   logic [7:0]  anim_phase_q [4];
   logic [7:0]  warp_offset_q [2];

   plasma_pixel_type pending_pixels [$];

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int error_count    = 0;
   int pixel_count    = 0;
   int setting_count  = 0;
   int idle_cycles    = 0;

   plasma_pixel_generator_unit DUT (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_x         (req_x),
      .req_y         (req_y),
      .req_frame_end (req_frame_end),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_x_dst     (rsp_x_dst),
      .rsp_y_dst     (rsp_y_dst),
      .rsp_shade     (rsp_shade),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wr_data   (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic int unsigned cosine_level(input int unsigned angle);
      int unsigned a;
      a = angle & 255;
      if (a > 128) begin
         a = 256 - a;
      end
      if (a <= 64) begin
         return QuarterCos[a];
      end
      return 63 - QuarterCos[128 - a];
   endfunction

   function automatic int unsigned clamped_log2(input logic [3:0] v);
      if (v < 1) begin
         return 1;
      end
      if (v > 8) begin
         return 8;
      end
      return v;
   endfunction

   // shade and warp of one pixel, then frame advance on frame_end
   task automatic compute_plasma_pixel(input logic [7:0] x, input logic [7:0] y,
                                       input logic fend);
      int unsigned wl, hl, sw, sh, wmask, hmask, xm, ym, shade, xcst, thex, they;
      plasma_pixel_type px;
      wl = clamped_log2(width_log2_q);
      hl = clamped_log2(height_log2_q);
      sw = 8 - wl;
      sh = 8 - hl;
      wmask = (1 << wl) - 1;
      hmask = (1 << hl) - 1;
      xm = x & wmask;
      ym = y & hmask;
      shade = cosine_level(anim_phase_q[0] + ((xm * line_steps_q[7:0]) << sw))
            + cosine_level(anim_phase_q[1] + ((xm * line_steps_q[15:8]) << sw))
            + cosine_level(anim_phase_q[2] + ((ym * line_steps_q[23:16]) << sw))
            + cosine_level(anim_phase_q[3] + ((ym * line_steps_q[31:24]) << sw));
      xcst = cosine_level((ym << sh) + warp_offset_q[0]) >> sw;
      thex = xm + xcst;
      they = ym + (cosine_level((thex << sw) + warp_offset_q[1]) >> sh);
      px.x_dst = 8'(thex & wmask);
      px.y_dst = 8'(they & hmask);
      px.shade = 8'(shade);
      pending_pixels.push_back(px);
      if (fend) begin
         for (int k = 0; k < 4; k++) begin
            anim_phase_q[k] = anim_phase_q[k] + frame_steps_q[8*k +: 8];
         end
         for (int k = 0; k < 2; k++) begin
            warp_offset_q[k] = warp_offset_q[k] + offset_steps_q[8*k +: 8];
         end
      end
   endtask

   task automatic send_pixel(input logic [7:0] x, input logic [7:0] y,
                             input logic fend);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_x         <= x;
      req_y         <= y;
      req_frame_end <= fend;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
      compute_plasma_pixel(x, y, fend);
      pixel_count++;
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= data;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (6) @(posedge clock);
   endtask

   task automatic configure(input logic [3:0] wl, input logic [3:0] hl,
                            input logic [31:0] ls, input logic [31:0] fs,
                            input logic [15:0] os);
      wait_drained();
      write_reg(CSR_WIDTH_LOG2, 32'(wl));
      write_reg(CSR_HEIGHT_LOG2, 32'(hl));
      write_reg(CSR_LINE_STEPS, ls);
      write_reg(CSR_FRAME_STEPS, fs);
      write_reg(CSR_OFFSET_STEPS, 32'(os));
      csr_wr_en <= 1'b0;
      @(posedge clock);
      width_log2_q   = wl;
      height_log2_q  = hl;
      line_steps_q   = ls;
      frame_steps_q  = fs;
      offset_steps_q = os;
      setting_count++;
   endtask

   task automatic test_reset_settings();
      send_pixel(8'd0, 8'd0, 1'b0);
      send_pixel(8'd63, 8'd63, 1'b0);
      send_pixel(8'd255, 8'd255, 1'b0);
      send_pixel(8'd64, 8'd128, 1'b0);
      send_pixel(8'd1, 8'd2, 1'b1);
      send_pixel(8'd1, 8'd2, 1'b0);
      send_pixel(8'd200, 8'd17, 1'b1);
   endtask

   task automatic test_size_extremes();
      // sizes below and above range are clamped
      configure(4'd0, 4'd15, 32'hFFFF_FFFF, 32'h8080_8080, 16'h7F80);
      send_pixel(8'd0, 8'd0, 1'b0);
      send_pixel(8'd1, 8'd255, 1'b1);
      send_pixel(8'd255, 8'd128, 1'b0);
      send_pixel(8'd170, 8'd85, 1'b1);
      configure(4'd15, 4'd0, 32'h0000_0000, 32'h7F7F_7F7F, 16'hFFFF);
      send_pixel(8'd255, 8'd255, 1'b1);
      send_pixel(8'd0, 8'd1, 1'b0);
      send_pixel(8'd128, 8'd64, 1'b1);
      send_pixel(8'd85, 8'd170, 1'b0);
      configure(4'd1, 4'd8, 32'h7F80_01FF, 32'hFFFF_FFFF, 16'h0000);
      send_pixel(8'd3, 8'd255, 1'b1);
      send_pixel(8'd2, 8'd0, 1'b0);
      send_pixel(8'd255, 8'd127, 1'b1);
      send_pixel(8'd0, 8'd254, 1'b0);
   endtask

   task automatic test_random_frames(input int idle_pct, input int stall_pct);
      int unsigned wmax, hmax, sx, sy;
      logic [31:0] ls, fs;
      logic [7:0]  x, y;
      logic        fend, raster;
      for (int c = 0; c < 4; c++) begin
         ls = ($urandom_range(7) == 0) ? {32{$urandom_range(1) == 1}} : $urandom;
         fs = ($urandom_range(7) == 0) ? 32'h0 : $urandom;
         configure(($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8)),
                   ($urandom_range(4) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(1, 8)),
                   ls, fs, 16'($urandom));
         send_idle_pct  = idle_pct;
         recv_stall_pct = stall_pct;
         wmax   = (1 << clamped_log2(width_log2_q)) - 1;
         hmax   = (1 << clamped_log2(height_log2_q)) - 1;
         raster = (c % 2 == 0);
         sx = 0;
         sy = 0;
         for (int n = 0; n < 80; n++) begin
            if (raster && $urandom_range(9) != 0) begin
               x = 8'(sx);
               y = 8'(sy);
               fend = (sx == wmax && sy == hmax) || ($urandom_range(31) == 0);
               if (fend) begin
                  sx = 0;
                  sy = 0;
               end else if (sx == wmax) begin
                  sx = 0;
                  sy++;
               end else begin
                  sx++;
               end
            end else begin
               x = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(wmax));
               y = ($urandom_range(4) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(hmax));
               fend = ($urandom_range(11) == 0);
            end
            send_pixel(x, y, fend);
         end
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // result checker
   always @(posedge clock) begin
      plasma_pixel_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_pixels.size() == 0) begin
            $error("unexpected result beat: x_dst %0d y_dst %0d shade %0d",
                   rsp_x_dst, rsp_y_dst, rsp_shade);
            error_count++;
         end else begin
            want = pending_pixels.pop_front();
            if (rsp_x_dst !== want.x_dst) begin
               $error("x_dst: expected %0d, got %0d", want.x_dst, rsp_x_dst);
               error_count++;
            end
            if (rsp_y_dst !== want.y_dst) begin
               $error("y_dst: expected %0d, got %0d", want.y_dst, rsp_y_dst);
               error_count++;
            end
            if (rsp_shade !== want.shade) begin
               $error("shade: expected %0d, got %0d", want.shade, rsp_shade);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("watchdog: no beat for %0d cycles", IdleLimit);
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      width_log2_q     = RstWidthLog2;
      height_log2_q    = RstHeightLog2;
      line_steps_q     = RstLineSteps;
      frame_steps_q    = RstFrameSteps;
      offset_steps_q   = RstOffsetSteps;
      anim_phase_q     = '{default: 8'd0};
      warp_offset_q[0] = RstWarpOffset0;
      warp_offset_q[1] = RstWarpOffset1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_settings();
      test_size_extremes();
      test_random_frames(0, 0);
      test_random_frames(48, 0);
      test_random_frames(0, 48);
      test_random_frames(20, 20);
      wait_drained();
      repeat (10) @(posedge clock);
      $display("covered %0d pixel beats under %0d register settings,", pixel_count,
               setting_count);
      $display("with clamped sizes, wrapping phases, frame ends, gaps and stalls");
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
